// ===== rtl/core/image_header_dimension_parser_assert.svh =====
// ----------------------------------------------------------------------------
// image header dimension parser assertion macros
// concurrent checks shared by the parser rtl
// ----------------------------------------------------------------------------
`ifndef IMAGE_HEADER_DIMENSION_PARSER_ASSERT_SVH
`define IMAGE_HEADER_DIMENSION_PARSER_ASSERT_SVH

// same-cycle implication
`define IHDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define IHDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ihdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ihdp_pkg
// types, marker codes and helpers for the image header dimension parser
// ----------------------------------------------------------------------------
package ihdp_pkg;

    typedef enum logic [3:0] {
        PH_SIG0  = 4'd0,
        PH_JSIG  = 4'd1,
        PH_PSIG  = 4'd2,
        PH_PBODY = 4'd3,
        PH_JSEEK = 4'd4,
        PH_JMARK = 4'd5,
        PH_JSOF  = 4'd6,
        PH_JLEN  = 4'd7,
        PH_JSKIP = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        DEC_NONE = 2'd0,
        DEC_FAIL = 2'd1,
        DEC_OK   = 2'd2
    } dec_t;

    typedef struct packed {
        logic        found;
        logic [31:0] height;
        logic [31:0] width;
    } result_t;

    localparam logic [7:0] BYTE_FILL   = 8'hFF;
    localparam logic [7:0] JPEG_SOI    = 8'hD8;
    localparam logic [7:0] JPEG_SOF_LO = 8'hC0;
    localparam logic [7:0] JPEG_SOF_HI = 8'hCF;
    localparam logic [7:0] JPEG_DHT    = 8'hC4;
    localparam logic [7:0] JPEG_JPG    = 8'hC8;
    localparam logic [7:0] JPEG_DAC    = 8'hCC;
    localparam logic [7:0] JPEG_SOS    = 8'hDA;
    localparam logic [7:0] JPEG_EOI    = 8'hD9;
    localparam logic [7:0] PNG_SIG0    = 8'h89;
    localparam logic [7:0] PNG_SIG1    = 8'h50;
    localparam logic [7:0] PNG_SIG2    = 8'h4E;
    localparam logic [7:0] PNG_SIG3    = 8'h47;

    localparam logic [4:0] PNG_SIG_END = 5'd4;
    localparam logic [4:0] PNG_W_FIRST = 5'd16;
    localparam logic [4:0] PNG_W_LAST  = 5'd19;
    localparam logic [4:0] PNG_H_FIRST = 5'd20;
    localparam logic [4:0] PNG_H_LAST  = 5'd23;

    localparam logic [2:0] SOF_H_HI = 3'd3;
    localparam logic [2:0] SOF_H_LO = 3'd4;
    localparam logic [2:0] SOF_W_HI = 3'd5;
    localparam logic [2:0] SOF_W_LO = 3'd6;
    localparam logic [2:0] SOF_DONE = 3'd7;

    function automatic logic is_sof(input logic [7:0] b);
        return (b >= JPEG_SOF_LO) && (b <= JPEG_SOF_HI) &&
               (b != JPEG_DHT) && (b != JPEG_JPG) && (b != JPEG_DAC);
    endfunction

    function automatic logic [7:0] png_sig(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0: v = PNG_SIG0;
            2'd1: v = PNG_SIG1;
            2'd2: v = PNG_SIG2;
            2'd3: v = PNG_SIG3;
            default: v = PNG_SIG0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/image_header_dimension_parser.sv =====
// ----------------------------------------------------------------------------
// image_header_dimension_parser
// reads jpeg or png file bytes and gives one width/height result per file
// ----------------------------------------------------------------------------
//  channel | dir | tdata                        | tuser | tlast
//  s_      | in  | [7:0] data_byte              | -     | end_of_file
//  m_      | out | [31:0] width, [63:32] height | found | -
//
//  one byte beat per cycle while s_tready is high; parse state moves on the accepted beat itself
//  a result is registered into the output buffer on the accepted byte that decides it
//  two-entry output buffer: s_tready drops only while both entries are full
//  synchronous active-low reset clears parse state and both output entries
// ----------------------------------------------------------------------------
`include "image_header_dimension_parser_assert.svh"

module image_header_dimension_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] width, [63:32] height
    output logic        m_tuser    // [0] found
);

    ihdp_pkg::phase_t  phase_reg, phase_next;
    logic [4:0]        pos_reg, pos_next;
    logic [15:0]       seg_reg, seg_next;
    logic [2:0]        field_reg, field_next;
    logic [31:0]       w_reg, w_next;
    logic [31:0]       h_reg, h_next;
    logic              reported_reg;
    ihdp_pkg::dec_t    dec;

    logic              out_valid_reg, skid_valid_reg;
    ihdp_pkg::result_t out_reg, skid_reg, res;

    logic              s_accept, m_pop, res_push;
    logic [15:0]       len_full, len_less, seg_dec;
    logic [4:0]        pos_inc;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_pop    = out_valid_reg && m_tready;
    assign m_tdata  = {out_reg.height, out_reg.width};
    assign m_tuser  = out_reg.found;

    assign len_full = seg_reg | {8'h00, s_tdata};
    assign len_less = len_full - 16'd2;
    assign seg_dec  = seg_reg - {15'd0, (seg_reg != 16'd0)};
    assign pos_inc  = pos_reg + 5'd1;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        seg_next   = seg_reg;
        field_next = field_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        dec        = ihdp_pkg::DEC_NONE;
        unique case (phase_reg)
            ihdp_pkg::PH_SIG0: begin
                if (s_tdata == ihdp_pkg::BYTE_FILL) begin
                    phase_next = ihdp_pkg::PH_JSIG;
                end else if (s_tdata == ihdp_pkg::PNG_SIG0) begin
                    phase_next = ihdp_pkg::PH_PSIG;
                    pos_next   = 5'd1;
                end else begin
                    dec = ihdp_pkg::DEC_FAIL;
                end
            end
            ihdp_pkg::PH_JSIG: begin
                if (s_tdata != ihdp_pkg::JPEG_SOI) begin
                    dec = ihdp_pkg::DEC_FAIL;
                end else begin
                    phase_next = ihdp_pkg::PH_JSEEK;
                end
            end
            ihdp_pkg::PH_PSIG: begin
                if (s_tdata != ihdp_pkg::png_sig(pos_reg[1:0])) begin
                    dec = ihdp_pkg::DEC_FAIL;
                end else begin
                    pos_next = pos_inc;
                    if (pos_inc >= ihdp_pkg::PNG_SIG_END) begin
                        phase_next = ihdp_pkg::PH_PBODY;
                    end
                end
            end
            ihdp_pkg::PH_PBODY: begin
                if (pos_reg >= ihdp_pkg::PNG_W_FIRST && pos_reg <= ihdp_pkg::PNG_W_LAST) begin
                    w_next = {w_reg[23:0], s_tdata};
                end else if (pos_reg >= ihdp_pkg::PNG_H_FIRST &&
                             pos_reg <= ihdp_pkg::PNG_H_LAST) begin
                    h_next = {h_reg[23:0], s_tdata};
                end
                if (pos_reg >= ihdp_pkg::PNG_H_LAST) begin
                    dec = ihdp_pkg::DEC_OK;
                end else begin
                    pos_next = pos_inc;
                end
            end
            ihdp_pkg::PH_JSEEK: begin
                if (s_tdata != ihdp_pkg::BYTE_FILL) begin
                    dec = ihdp_pkg::DEC_FAIL;
                end else begin
                    phase_next = ihdp_pkg::PH_JMARK;
                end
            end
            ihdp_pkg::PH_JMARK: begin
                if (s_tdata == ihdp_pkg::BYTE_FILL) begin
                    phase_next = ihdp_pkg::PH_JMARK;
                end else if (s_tdata == ihdp_pkg::JPEG_SOS || s_tdata == ihdp_pkg::JPEG_EOI) begin
                    dec = ihdp_pkg::DEC_FAIL;
                end else begin
                    field_next = 3'd0;
                    if (ihdp_pkg::is_sof(s_tdata)) begin
                        phase_next = ihdp_pkg::PH_JSOF;
                    end else begin
                        seg_next   = 16'd0;
                        phase_next = ihdp_pkg::PH_JLEN;
                    end
                end
            end
            ihdp_pkg::PH_JSOF: begin
                if (field_reg == ihdp_pkg::SOF_H_HI || field_reg == ihdp_pkg::SOF_H_LO) begin
                    h_next = {16'd0, h_reg[7:0], s_tdata};
                end else if (field_reg == ihdp_pkg::SOF_W_HI ||
                             field_reg == ihdp_pkg::SOF_W_LO) begin
                    w_next = {16'd0, w_reg[7:0], s_tdata};
                end
                if (field_reg >= ihdp_pkg::SOF_DONE) begin
                    dec = ihdp_pkg::DEC_OK;
                end else begin
                    field_next = field_reg + 3'd1;
                end
            end
            ihdp_pkg::PH_JLEN: begin
                if (field_reg == 3'd0) begin
                    seg_next   = {s_tdata, 8'h00};
                    field_next = 3'd1;
                end else if (len_full < 16'd2) begin
                    seg_next = len_full;
                    dec      = ihdp_pkg::DEC_FAIL;
                end else begin
                    seg_next   = len_less;
                    phase_next = (len_less != 16'd0) ? ihdp_pkg::PH_JSKIP : ihdp_pkg::PH_JSEEK;
                end
            end
            ihdp_pkg::PH_JSKIP: begin
                seg_next = seg_dec;
                if (seg_dec == 16'd0) begin
                    phase_next = ihdp_pkg::PH_JSEEK;
                end
            end
            default: begin
                dec = ihdp_pkg::DEC_FAIL;
            end
        endcase
        if (dec == ihdp_pkg::DEC_NONE && s_tlast) begin
            dec = ihdp_pkg::DEC_FAIL;
        end
    end

    always_comb begin
        res.found  = (dec == ihdp_pkg::DEC_OK);
        res.width  = (dec == ihdp_pkg::DEC_OK) ? w_next : 32'd0;
        res.height = (dec == ihdp_pkg::DEC_OK) ? h_next : 32'd0;
    end

    assign res_push = s_accept && !reported_reg && (dec != ihdp_pkg::DEC_NONE);

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= ihdp_pkg::PH_SIG0;
            pos_reg      <= 5'd0;
            seg_reg      <= 16'd0;
            field_reg    <= 3'd0;
            w_reg        <= 32'd0;
            h_reg        <= 32'd0;
            reported_reg <= 1'b0;
        end else if (s_accept) begin
            if (s_tlast) begin
                phase_reg    <= ihdp_pkg::PH_SIG0;
                pos_reg      <= 5'd0;
                seg_reg      <= 16'd0;
                field_reg    <= 3'd0;
                w_reg        <= 32'd0;
                h_reg        <= 32'd0;
                reported_reg <= 1'b0;
            end else if (!reported_reg) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                seg_reg   <= seg_next;
                field_reg <= field_next;
                w_reg     <= w_next;
                h_reg     <= h_next;
                if (dec != ihdp_pkg::DEC_NONE) begin
                    reported_reg <= 1'b1;
                end
            end
        end
    end

    // output buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= res_push;
                end
            end else if (out_valid_reg) begin
                if (res_push) begin
                    skid_valid_reg <= 1'b1;
                end
            end else begin
                out_valid_reg <= res_push;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge aclk) begin
        if (m_pop && skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (res_push && (m_pop || !out_valid_reg)) begin
            out_reg <= res;
        end
        if (res_push && out_valid_reg && !m_pop) begin
            skid_reg <= res;
        end
    end

    `IHDP_ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `IHDP_ASSERT_IMPL(a_no_result_after_report, aclk, aresetn, s_accept && reported_reg, !res_push)
    `IHDP_ASSERT_IMPL(a_eof_gives_result, aclk, aresetn, s_accept && s_tlast && !reported_reg, res_push)
    `IHDP_ASSERT_NEXT(a_eof_restarts, aclk, aresetn, s_accept && s_tlast,
                      phase_reg == ihdp_pkg::PH_SIG0 && !reported_reg)
    `IHDP_ASSERT_NEXT(a_push_shows, aclk, aresetn, res_push, m_tvalid)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the image header dimension parser: jpeg and png
// byte streams, well-formed and damaged, go in beat by beat under random
// stalls on both channels; a scoreboard predicts the per-file result and
// compares every returned beat with it field by field
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_BEATS = 1250;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic        found;
        logic [31:0] width;
        logic [31:0] height;
    } dims_t;

    class dimension_scoreboard;
        ihdp_pkg::phase_t phase;
        logic [4:0]       png_pos;
        logic [15:0]      seg_left;
        logic [2:0]       field_pos;
        logic [31:0]      width_acc;
        logic [31:0]      height_acc;
        bit               decided;
        dims_t            expected_dims[$];
        int               mismatch_count;

        function new();
            mismatch_count = 0;
            clear_file();
        endfunction

        static function bit is_frame_start(logic [7:0] b);
            case (b)
                ihdp_pkg::JPEG_DHT, ihdp_pkg::JPEG_JPG, ihdp_pkg::JPEG_DAC: return 1'b0;
                default: return b[7:4] == ihdp_pkg::JPEG_SOF_LO[7:4];
            endcase
        endfunction

        function void clear_file();
            phase      = ihdp_pkg::PH_SIG0;
            png_pos    = '0;
            seg_left   = '0;
            field_pos  = '0;
            width_acc  = '0;
            height_acc = '0;
            decided    = 1'b0;
        endfunction

        function ihdp_pkg::dec_t parse_byte(logic [7:0] b);
            logic [31:0] sig_word;
            sig_word = {ihdp_pkg::PNG_SIG3, ihdp_pkg::PNG_SIG2,
                        ihdp_pkg::PNG_SIG1, ihdp_pkg::PNG_SIG0};
            case (phase)
                ihdp_pkg::PH_SIG0: begin
                    if (b == ihdp_pkg::BYTE_FILL) begin
                        phase = ihdp_pkg::PH_JSIG;
                    end else if (b == ihdp_pkg::PNG_SIG0) begin
                        phase   = ihdp_pkg::PH_PSIG;
                        png_pos = 5'd1;
                    end else begin
                        return ihdp_pkg::DEC_FAIL;
                    end
                end
                ihdp_pkg::PH_JSIG: begin
                    if (b != ihdp_pkg::JPEG_SOI) return ihdp_pkg::DEC_FAIL;
                    phase = ihdp_pkg::PH_JSEEK;
                end
                ihdp_pkg::PH_PSIG: begin
                    if (b != sig_word[png_pos[1:0] * 8 +: 8]) return ihdp_pkg::DEC_FAIL;
                    png_pos = png_pos + 5'd1;
                    if (png_pos >= ihdp_pkg::PNG_SIG_END) phase = ihdp_pkg::PH_PBODY;
                end
                ihdp_pkg::PH_PBODY: begin
                    if (png_pos >= ihdp_pkg::PNG_W_FIRST && png_pos <= ihdp_pkg::PNG_W_LAST)
                        width_acc = {width_acc[23:0], b};
                    else if (png_pos >= ihdp_pkg::PNG_H_FIRST && png_pos <= ihdp_pkg::PNG_H_LAST)
                        height_acc = {height_acc[23:0], b};
                    if (png_pos >= ihdp_pkg::PNG_H_LAST) return ihdp_pkg::DEC_OK;
                    png_pos = png_pos + 5'd1;
                end
                ihdp_pkg::PH_JSEEK: begin
                    if (b != ihdp_pkg::BYTE_FILL) return ihdp_pkg::DEC_FAIL;
                    phase = ihdp_pkg::PH_JMARK;
                end
                ihdp_pkg::PH_JMARK: begin
                    if (b == ihdp_pkg::BYTE_FILL) return ihdp_pkg::DEC_NONE;
                    if (b == ihdp_pkg::JPEG_SOS || b == ihdp_pkg::JPEG_EOI)
                        return ihdp_pkg::DEC_FAIL;
                    field_pos = '0;
                    if (is_frame_start(b)) begin
                        phase = ihdp_pkg::PH_JSOF;
                    end else begin
                        seg_left = '0;
                        phase    = ihdp_pkg::PH_JLEN;
                    end
                end
                ihdp_pkg::PH_JSOF: begin
                    if (field_pos == ihdp_pkg::SOF_H_HI || field_pos == ihdp_pkg::SOF_H_LO)
                        height_acc = {16'h0000, height_acc[7:0], b};
                    else if (field_pos == ihdp_pkg::SOF_W_HI || field_pos == ihdp_pkg::SOF_W_LO)
                        width_acc = {16'h0000, width_acc[7:0], b};
                    if (field_pos == ihdp_pkg::SOF_DONE) return ihdp_pkg::DEC_OK;
                    field_pos = field_pos + 3'd1;
                end
                ihdp_pkg::PH_JLEN: begin
                    if (field_pos == 3'd0) begin
                        seg_left  = {b, 8'h00};
                        field_pos = 3'd1;
                    end else begin
                        seg_left = seg_left | {8'h00, b};
                        if (seg_left < 16'd2) return ihdp_pkg::DEC_FAIL;
                        seg_left = seg_left - 16'd2;
                        phase    = (seg_left != 16'd0) ? ihdp_pkg::PH_JSKIP
                                                       : ihdp_pkg::PH_JSEEK;
                    end
                end
                ihdp_pkg::PH_JSKIP: begin
                    if (seg_left != 16'd0) seg_left = seg_left - 16'd1;
                    if (seg_left == 16'd0) phase = ihdp_pkg::PH_JSEEK;
                end
                default: return ihdp_pkg::DEC_FAIL;
            endcase
            return ihdp_pkg::DEC_NONE;
        endfunction

        function void note_beat(logic [7:0] b, logic eof);
            ihdp_pkg::dec_t d;
            dims_t          r;
            if (!decided) begin
                d = parse_byte(b);
                if (d == ihdp_pkg::DEC_NONE && eof) d = ihdp_pkg::DEC_FAIL;
                if (d != ihdp_pkg::DEC_NONE) begin
                    r.found  = (d == ihdp_pkg::DEC_OK);
                    r.width  = r.found ? width_acc : 32'd0;
                    r.height = r.found ? height_acc : 32'd0;
                    expected_dims.push_back(r);
                    decided = 1'b1;
                end
            end
            if (eof) clear_file();
        endfunction

        function void check_result(logic found, logic [31:0] width, logic [31:0] height);
            dims_t e;
            if (expected_dims.size() == 0) begin
                $error("result beat with nothing expected: found %0d width %0d height %0d",
                       found, width, height);
                mismatch_count++;
                return;
            end
            e = expected_dims.pop_front();
            if (found !== e.found) begin
                $error("found: expected %0d, actual %0d", e.found, found);
                mismatch_count++;
            end
            if (width !== e.width) begin
                $error("width: expected %0d, actual %0d", e.width, width);
                mismatch_count++;
            end
            if (height !== e.height) begin
                $error("height: expected %0d, actual %0d", e.height, height);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_dims.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [63:0] m_tdata;
    logic        m_tuser;

    dimension_scoreboard board = new();
    logic [7:0] file_bytes[$];
    bit         idle_on = 1'b1;
    int         hold_left = 0;
    int         sent_bytes = 0;
    int         cycle_count = 0;

    image_header_dimension_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: check accepted beats, stall in random bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata[31:0], m_tdata[63:32]);
        if (!aresetn || !idle_on) begin
            m_tready  <= 1'b1;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_tready  <= 1'b0;
            hold_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_byte(logic [7:0] b, logic eof);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        do @(posedge aclk); while (!s_tready);
        board.note_beat(b, eof);
    endtask

    task automatic send_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            push_byte(file_bytes[i], i == file_bytes.size() - 1);
        sent_bytes += file_bytes.size();
        file_bytes.delete();
    endtask

    function automatic logic [31:0] pick_size(logic [31:0] mask);
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return mask;
            default: return $urandom & mask;
        endcase
    endfunction

    function automatic logic [7:0] pick_plain_marker();
        logic [7:0] m;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0:       return ihdp_pkg::JPEG_DHT;
                1:       return ihdp_pkg::JPEG_JPG;
                default: return ihdp_pkg::JPEG_DAC;
            endcase
        end
        do m = 8'($urandom);
        while (m == ihdp_pkg::BYTE_FILL || m == ihdp_pkg::JPEG_SOS || m == ihdp_pkg::JPEG_EOI ||
               dimension_scoreboard::is_frame_start(m));
        return m;
    endfunction

    // marker with optional fill bytes ahead of the code
    function automatic void add_marker(logic [7:0] code);
        file_bytes.push_back(ihdp_pkg::BYTE_FILL);
        repeat ($urandom_range(0, 2)) file_bytes.push_back(ihdp_pkg::BYTE_FILL);
        file_bytes.push_back(code);
    endfunction

    task automatic make_random_file();
        int          kind;
        int          cut;
        logic [7:0]  m;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] len;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            file_bytes = '{ihdp_pkg::PNG_SIG0, ihdp_pkg::PNG_SIG1,
                           ihdp_pkg::PNG_SIG2, ihdp_pkg::PNG_SIG3};
            repeat (12) file_bytes.push_back(8'($urandom));
            w = pick_size(32'hFFFF_FFFF);
            h = pick_size(32'hFFFF_FFFF);
            for (int k = 3; k >= 0; k--) file_bytes.push_back(w[k * 8 +: 8]);
            for (int k = 3; k >= 0; k--) file_bytes.push_back(h[k * 8 +: 8]);
        end else if (kind <= 7) begin
            file_bytes = '{ihdp_pkg::BYTE_FILL, ihdp_pkg::JPEG_SOI};
            repeat ($urandom_range(0, 3)) begin
                add_marker(pick_plain_marker());
                len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(256, 300))
                                                  : 16'($urandom_range(2, 8));
                file_bytes.push_back(len[15:8]);
                file_bytes.push_back(len[7:0]);
                repeat (len - 2) file_bytes.push_back(8'($urandom));
            end
            do m = 8'($urandom_range(ihdp_pkg::JPEG_SOF_LO, ihdp_pkg::JPEG_SOF_HI));
            while (!dimension_scoreboard::is_frame_start(m));
            add_marker(m);
            w = pick_size(32'h0000_FFFF);
            h = pick_size(32'h0000_FFFF);
            repeat (3) file_bytes.push_back(8'($urandom));
            file_bytes.push_back(h[15:8]);
            file_bytes.push_back(h[7:0]);
            file_bytes.push_back(w[15:8]);
            file_bytes.push_back(w[7:0]);
            file_bytes.push_back(8'($urandom));
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    repeat ($urandom_range(1, 8)) begin
                        case ($urandom_range(0, 6))
                            0:       file_bytes.push_back(ihdp_pkg::BYTE_FILL);
                            1:       file_bytes.push_back(ihdp_pkg::JPEG_SOI);
                            2:       file_bytes.push_back(ihdp_pkg::PNG_SIG0);
                            3:       file_bytes.push_back(ihdp_pkg::PNG_SIG1);
                            4:       file_bytes.push_back(ihdp_pkg::PNG_SIG2);
                            5:       file_bytes.push_back(ihdp_pkg::PNG_SIG3);
                            default: file_bytes.push_back(8'($urandom));
                        endcase
                    end
                end
                1: begin
                    file_bytes = '{ihdp_pkg::BYTE_FILL, ihdp_pkg::JPEG_SOI};
                    add_marker($urandom_range(0, 1) ? ihdp_pkg::JPEG_SOS : ihdp_pkg::JPEG_EOI);
                end
                2: begin
                    file_bytes = '{ihdp_pkg::BYTE_FILL, ihdp_pkg::JPEG_SOI};
                    add_marker(pick_plain_marker());
                    file_bytes.push_back(8'h00);
                    file_bytes.push_back(8'($urandom_range(0, 1)));
                end
                default: begin
                    file_bytes = '{ihdp_pkg::BYTE_FILL, ihdp_pkg::JPEG_SOI};
                    file_bytes.push_back(8'($urandom_range(0, 254)));
                end
            endcase
        end
        // trailing bytes after the decision, or an early end of file
        repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
        if (kind <= 7 && $urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            file_bytes = file_bytes[0:cut - 1];
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // unknown first byte, ending on the same beat
        file_bytes = '{8'h00};
        send_file();
        // fill byte not followed by start of image
        file_bytes = '{ihdp_pkg::BYTE_FILL, 8'h00};
        send_file();
        // png signature broken on its last byte
        file_bytes = '{ihdp_pkg::PNG_SIG0, ihdp_pkg::PNG_SIG1, ihdp_pkg::PNG_SIG2, 8'h00};
        send_file();
        // end of file before any decision
        file_bytes = '{ihdp_pkg::BYTE_FILL};
        send_file();
        // stray byte where a marker belongs, then ignored bytes
        file_bytes = '{ihdp_pkg::BYTE_FILL, ihdp_pkg::JPEG_SOI, 8'h12, 8'h34};
        send_file();
        // fill bytes then start of scan
        file_bytes = '{ihdp_pkg::BYTE_FILL, ihdp_pkg::JPEG_SOI, ihdp_pkg::BYTE_FILL,
                       ihdp_pkg::BYTE_FILL, ihdp_pkg::JPEG_SOS};
        send_file();
        // end of image marker
        file_bytes = '{ihdp_pkg::BYTE_FILL, ihdp_pkg::JPEG_SOI, ihdp_pkg::BYTE_FILL,
                       ihdp_pkg::JPEG_EOI};
        send_file();
        // segment length below two
        file_bytes = '{ihdp_pkg::BYTE_FILL, ihdp_pkg::JPEG_SOI, ihdp_pkg::BYTE_FILL,
                       ihdp_pkg::JPEG_DHT, 8'h00, 8'h01};
        send_file();

        sent_bytes = 0;
        while (sent_bytes < RANDOM_BEATS) begin
            idle_on = (sent_bytes < RANDOM_BEATS - 200) && ($urandom_range(0, 3) != 0);
            make_random_file();
            send_file();
        end
        s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ihdp_pkg.sv
rtl/core/image_header_dimension_parser.sv
bench/tb_top.sv
